@@ rtl/dfc_pkg.sv @@
// Package for the distance follow controller: item, result, config and control types.
`timescale 1ns / 1ps
`default_nettype none

package dfc_pkg;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_GO_SPEED     = 3'd0;
    localparam logic [2:0] REG_NEAR_MM      = 3'd1;
    localparam logic [2:0] REG_MAX_VALID_MM = 3'd2;
    localparam logic [2:0] REG_BRAKE_TICKS  = 3'd3;
    localparam logic [2:0] REG_POLL_TICKS   = 3'd4;
    localparam logic [2:0] REG_HEADING_GAIN = 3'd5;
    localparam logic [2:0] REG_TURN_LIMIT   = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [9:0]         GO_SPEED_RST     = 10'd450;
    localparam logic [15:0]        NEAR_MM_RST      = 16'd500;
    localparam logic [15:0]        MAX_VALID_MM_RST = 16'd4000;
    localparam logic [7:0]         BRAKE_TICKS_RST  = 8'd20;
    localparam logic [7:0]         POLL_TICKS_RST   = 8'd10;
    localparam logic signed [10:0] HEADING_GAIN_RST = -11'sd85;
    localparam logic [14:0]        TURN_LIMIT_RST   = 15'd250;

    // heading error wrap bounds, centidegrees
    localparam int ERR_W = 18;
    localparam logic signed [ERR_W-1:0] HALF_TURN    = 18'sd18000;
    localparam logic signed [ERR_W-1:0] ONE_TURN     = 18'sd36000;
    localparam logic signed [ERR_W-1:0] THREE_HALVES = 18'sd54000;
    localparam logic signed [ERR_W-1:0] TWO_TURNS    = 18'sd72000;

    // |err * gain| < 2^25; floor(x / 1000) = (x * ceil(2^35 / 1000)) >> 35 for x < 2^25
    localparam int PROD_W    = 25;
    localparam int RECIP_W   = 26;
    localparam int DIV_SHIFT = 35;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 26'd34359739;

    typedef enum logic [1:0] {
        MODE_STOP  = 2'd0,
        MODE_GO    = 2'd1,
        MODE_BRAKE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        TURN_HOLD,
        TURN_ZERO,
        TURN_CALC
    } turn_op_t;

    typedef struct packed {
        logic [1:0]         command;
        logic               kill_active;
        logic               sensor_ready;
        logic               sample_done;
        logic [15:0]        distance_mm;
        logic signed [15:0] yaw_cdeg;
    } item_t;

    typedef struct packed {
        logic               cmd_active;
        logic [9:0]         speed_out;
        logic signed [15:0] turn_out;
        logic               poll_request;
        logic [1:0]         follow_state;
    } result_t;

    typedef struct packed {
        logic [9:0]         go_speed;
        logic [15:0]        near_threshold_mm;
        logic [15:0]        max_valid_mm;
        logic [7:0]         brake_ticks;
        logic [7:0]         poll_ticks;
        logic signed [10:0] heading_gain_tenths;
        logic [14:0]        turn_limit;
    } cfg_t;

    // result fields decided by the state machine, carried down the turn pipe
    typedef struct packed {
        logic       active;
        logic [9:0] speed;
        logic       poll;
        logic [1:0] state;
        turn_op_t   op;
    } out_ctl_t;

    typedef struct packed {
        out_ctl_t    info;
        logic [14:0] err_mag;
        logic        err_neg;
    } ctl_t;

endpackage

`default_nettype wire

@@ rtl/dfc_ctrl.sv @@
// Follow state machine, poll divider, heading latch and wrapped heading error.
`timescale 1ns / 1ps
`default_nettype none

module dfc_ctrl
    import dfc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  accept,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output ctl_t       ctl_next
);

    mode_t              mode_reg, mode_next;
    logic signed [15:0] heading_target_reg, heading_target_next;
    logic               heading_latched_reg, heading_latched_next;
    logic [7:0]         poll_count_reg, poll_count_next;
    logic [7:0]         brake_count_reg, brake_count_next;
    logic               last_active_reg, last_active_next;
    logic [9:0]         last_speed_reg, last_speed_next;

    logic                    dist_valid;
    logic [8:0]              poll_sum;
    logic [8:0]              brake_sum;
    logic                    poll;
    turn_op_t                op;
    logic signed [ERR_W-1:0] diff;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] err_abs;

    always_comb
    begin
        dist_valid = item.sensor_ready && item.sample_done
                     && (item.distance_mm <= cfg.max_valid_mm);
        poll_sum  = {1'b0, poll_count_reg} + 9'd1;
        brake_sum = {1'b0, brake_count_reg} + 9'd1;

        mode_next            = mode_reg;
        heading_target_next  = heading_target_reg;
        heading_latched_next = heading_latched_reg;
        poll_count_next      = poll_count_reg;
        brake_count_next     = brake_count_reg;
        last_active_next     = last_active_reg;
        last_speed_next      = last_speed_reg;
        poll                 = 1'b0;
        op                   = TURN_HOLD;

        if (item.command == CMD_START)
        begin
            mode_next = MODE_STOP;
            if (!heading_latched_reg)
            begin
                heading_target_next  = item.yaw_cdeg;
                heading_latched_next = 1'b1;
            end
            poll_count_next  = '0;
            brake_count_next = '0;
            last_active_next = 1'b1;
            last_speed_next  = '0;
            op               = TURN_ZERO;
        end
        else if (item.command == CMD_STOP)
        begin
            mode_next        = MODE_STOP;
            brake_count_next = '0;
            last_active_next = 1'b0;
            last_speed_next  = '0;
            op               = TURN_ZERO;
        end
        else if (item.command == CMD_TICK && !item.kill_active)
        begin
            if (poll_sum >= {1'b0, cfg.poll_ticks})
            begin
                poll_count_next = '0;
                poll            = 1'b1;
            end
            else
            begin
                poll_count_next = poll_sum[7:0];
            end

            if (!dist_valid)
            begin
                mode_next        = MODE_STOP;
                brake_count_next = '0;
            end
            else
            begin
                case (mode_reg)
                    MODE_GO:
                    begin
                        if (item.distance_mm <= cfg.near_threshold_mm)
                        begin
                            mode_next        = MODE_BRAKE;
                            brake_count_next = '0;
                        end
                    end
                    MODE_BRAKE:
                    begin
                        if (brake_sum >= {1'b0, cfg.brake_ticks})
                            mode_next = MODE_STOP;
                        brake_count_next = brake_sum[8] ? 8'hFF : brake_sum[7:0];
                    end
                    default:
                    begin
                        if (item.distance_mm > cfg.near_threshold_mm)
                            mode_next = MODE_GO;
                    end
                endcase
            end

            last_active_next = 1'b1;
            if (mode_next == MODE_GO)
            begin
                last_speed_next = cfg.go_speed;
                op              = TURN_CALC;
            end
            else
            begin
                last_speed_next = '0;
                op              = TURN_ZERO;
            end
        end
    end

    // error lies in [-65535, 65535]: at most two turns to fold into (-180, 180]
    always_comb
    begin
        diff = ERR_W'(item.yaw_cdeg) - ERR_W'(heading_target_reg);
        if (diff > THREE_HALVES)
            err = diff - TWO_TURNS;
        else if (diff > HALF_TURN)
            err = diff - ONE_TURN;
        else if (diff <= -THREE_HALVES)
            err = diff + TWO_TURNS;
        else if (diff <= -HALF_TURN)
            err = diff + ONE_TURN;
        else
            err = diff;
        err_abs = err[ERR_W-1] ? -err : err;

        ctl_next.info.active = last_active_next;
        ctl_next.info.speed  = last_speed_next;
        ctl_next.info.poll   = poll;
        ctl_next.info.state  = mode_next;
        ctl_next.info.op     = op;
        ctl_next.err_mag     = err_abs[14:0];
        ctl_next.err_neg     = err[ERR_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg            <= MODE_STOP;
            heading_target_reg  <= '0;
            heading_latched_reg <= 1'b0;
            poll_count_reg      <= '0;
            brake_count_reg     <= '0;
            last_active_reg     <= 1'b0;
            last_speed_reg      <= '0;
        end
        else if (accept)
        begin
            mode_reg            <= mode_next;
            heading_target_reg  <= heading_target_next;
            heading_latched_reg <= heading_latched_next;
            poll_count_reg      <= poll_count_next;
            brake_count_reg     <= brake_count_next;
            last_active_reg     <= last_active_next;
            last_speed_reg      <= last_speed_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/distance_follow_controller.sv @@
// Top level of the distance follow controller: config registers and heading turn pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock while item_stall is low and returns one result per
// item, in order, through the s1, s2, s3 and result registers. The first stage
// runs the stop/go/brake machine, poll divider and heading error; the next three
// form the turn pipeline (error times gain, divide by 1000 through a reciprocal
// multiply, then sign and clamp into the result register). A stalled result
// only holds the input side once all four stages are full. Configuration writes
// take effect at the next edge and are meant to happen while no item is in flight.
module distance_follow_controller
    import dfc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_stall,
    input  wire item_t                  item,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_t                     result,
    input  wire logic                   cfg_write_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg_reg;
    ctl_t    ctl_next;

    logic    accept;
    logic    s1_en, s2_en, s3_en, out_en;

    logic    s1_valid_reg;
    ctl_t    s1_reg;
    logic    s2_valid_reg;
    out_ctl_t s2_info_reg;
    logic [PROD_W-1:0] s2_mag_reg;
    logic    s2_neg_reg;
    logic    s3_valid_reg;
    out_ctl_t s3_info_reg;
    logic [14:0] s3_q_reg;
    logic    s3_neg_reg;
    logic    result_valid_reg;
    result_t result_reg;
    logic signed [15:0] last_turn_reg, last_turn_next;

    logic                      gain_neg;
    logic [10:0]               gain_mag;
    logic [25:0]               prod;
    logic [PROD_W+RECIP_W-1:0] q_full;
    logic [14:0]               turn_mag;
    logic [15:0]               turn_calc;

    // bubble-collapsing enables
    assign out_en     = !result_valid_reg || !result_stall;
    assign s3_en      = !s3_valid_reg || out_en;
    assign s2_en      = !s2_valid_reg || s3_en;
    assign s1_en      = !s1_valid_reg || s2_en;
    assign item_stall = !s1_en;
    assign accept     = item_valid && s1_en;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.go_speed            <= GO_SPEED_RST;
            cfg_reg.near_threshold_mm   <= NEAR_MM_RST;
            cfg_reg.max_valid_mm        <= MAX_VALID_MM_RST;
            cfg_reg.brake_ticks         <= BRAKE_TICKS_RST;
            cfg_reg.poll_ticks          <= POLL_TICKS_RST;
            cfg_reg.heading_gain_tenths <= HEADING_GAIN_RST;
            cfg_reg.turn_limit          <= TURN_LIMIT_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_GO_SPEED:     cfg_reg.go_speed            <= cfg_data[9:0];
                REG_NEAR_MM:      cfg_reg.near_threshold_mm   <= cfg_data;
                REG_MAX_VALID_MM: cfg_reg.max_valid_mm        <= cfg_data;
                REG_BRAKE_TICKS:  cfg_reg.brake_ticks         <= cfg_data[7:0];
                REG_POLL_TICKS:   cfg_reg.poll_ticks          <= cfg_data[7:0];
                REG_HEADING_GAIN: cfg_reg.heading_gain_tenths <= cfg_data[10:0];
                REG_TURN_LIMIT:   cfg_reg.turn_limit          <= cfg_data[14:0];
                default:          ;
            endcase
        end
    end

    dfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg_reg),
        .ctl_next (ctl_next)
    );

    always_comb
    begin
        gain_neg = cfg_reg.heading_gain_tenths[10];
        gain_mag = gain_neg ? 11'(-cfg_reg.heading_gain_tenths)
                            : 11'(cfg_reg.heading_gain_tenths);
        prod     = 26'(s1_reg.err_mag) * 26'(gain_mag);
        q_full   = (PROD_W+RECIP_W)'(s2_mag_reg) * (PROD_W+RECIP_W)'(DIV_RECIP);

        turn_mag  = (s3_q_reg > cfg_reg.turn_limit) ? cfg_reg.turn_limit : s3_q_reg;
        turn_calc = s3_neg_reg ? -{1'b0, turn_mag} : {1'b0, turn_mag};

        case (s3_info_reg.op)
            TURN_CALC: last_turn_next = turn_calc;
            TURN_ZERO: last_turn_next = '0;
            default:   last_turn_next = last_turn_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            s3_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
            last_turn_reg    <= '0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= item_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
            if (s3_en)
                s3_valid_reg <= s2_valid_reg;
            if (out_en)
                result_valid_reg <= s3_valid_reg;
            if (out_en && s3_valid_reg)
                last_turn_reg <= last_turn_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_reg <= ctl_next;
        if (s2_en && s1_valid_reg)
        begin
            s2_info_reg <= s1_reg.info;
            s2_mag_reg  <= prod[PROD_W-1:0];
            s2_neg_reg  <= s1_reg.err_neg ^ gain_neg;
        end
        if (s3_en && s2_valid_reg)
        begin
            s3_info_reg <= s2_info_reg;
            s3_q_reg    <= q_full[DIV_SHIFT+14:DIV_SHIFT];
            s3_neg_reg  <= s2_neg_reg;
        end
        if (out_en && s3_valid_reg)
        begin
            result_reg.cmd_active   <= s3_info_reg.active;
            result_reg.speed_out    <= s3_info_reg.speed;
            result_reg.turn_out     <= last_turn_next;
            result_reg.poll_request <= s3_info_reg.poll;
            result_reg.follow_state <= s3_info_reg.state;
        end
    end

    // an empty first stage always takes an item
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> !item_stall)
        else $error("input stalled with empty first stage");

    // nonzero speed is only shown while the machine sits in go
    a_speed_in_go: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.speed_out != '0) |-> result.follow_state == MODE_GO)
        else $error("speed output outside go state");

    // a poll request only comes from a tick, which makes the command active
    a_poll_active: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.poll_request |-> result.cmd_active)
        else $error("poll request without active command");

    // a result moves on only when a stage behind it had one
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid_reg && !s3_valid_reg |=> !result_valid_reg)
        else $error("result appeared from an empty pipeline");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the distance follow controller: directed and random items checked against a local predictor.
`timescale 1ns / 1ps

module tb;
    import dfc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic result_stall = 1'b0;
    logic cfg_write_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    item_t item = '0;
    logic item_stall;
    logic result_valid;
    result_t result;

    distance_follow_controller dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    cfg_t cfg_m;
    mode_t mode_m = MODE_STOP;
    int hdg_target = 0;
    bit hdg_latched = 1'b0;
    int poll_cnt = 0;
    int brake_cnt = 0;
    logic last_active = 1'b0;
    logic [9:0] last_speed = '0;
    logic signed [15:0] last_turn = '0;

    result_t expected_q[$];
    int mismatches = 0;
    int idle_pct = 31;
    int stall_pct = 31;
    int hold_req = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic logic signed [15:0] turn_for_yaw(input logic signed [15:0] yaw);
        int err;
        int t;
        int gain;
        int lim;
        gain = int'(cfg_m.heading_gain_tenths);
        lim = int'(cfg_m.turn_limit);
        err = int'(yaw);
        err = err - hdg_target;
        while (err > 18000)
            err -= 36000;
        while (err <= -18000)
            err += 36000;
        t = (err * gain) / 1000;
        if (t < -lim)
            t = -lim;
        if (t > lim)
            t = lim;
        return 16'(t);
    endfunction

    function automatic result_t follow_step(input item_t it);
        result_t r;
        logic poll;
        bit ok;
        int d;
        int near_mm;
        poll = 1'b0;
        d = int'(it.distance_mm);
        near_mm = int'(cfg_m.near_threshold_mm);
        case (it.command)
            CMD_START:
            begin
                mode_m = MODE_STOP;
                if (!hdg_latched)
                begin
                    hdg_target = int'(it.yaw_cdeg);
                    hdg_latched = 1'b1;
                end
                poll_cnt = 0;
                brake_cnt = 0;
                last_active = 1'b1;
                last_speed = '0;
                last_turn = '0;
            end
            CMD_STOP:
            begin
                mode_m = MODE_STOP;
                brake_cnt = 0;
                last_active = 1'b0;
                last_speed = '0;
                last_turn = '0;
            end
            CMD_TICK:
            begin
                if (!it.kill_active)
                begin
                    ok = it.sensor_ready && it.sample_done && d <= int'(cfg_m.max_valid_mm);
                    poll_cnt = poll_cnt + 1;
                    if (poll_cnt >= int'(cfg_m.poll_ticks))
                    begin
                        poll_cnt = 0;
                        poll = 1'b1;
                    end
                    poll_cnt = poll_cnt & 255;
                    if (!ok)
                    begin
                        mode_m = MODE_STOP;
                        brake_cnt = 0;
                    end
                    else if (mode_m == MODE_GO)
                    begin
                        if (d <= near_mm)
                        begin
                            mode_m = MODE_BRAKE;
                            brake_cnt = 0;
                        end
                    end
                    else if (mode_m == MODE_BRAKE)
                    begin
                        brake_cnt = brake_cnt + 1;
                        if (brake_cnt >= int'(cfg_m.brake_ticks))
                            mode_m = MODE_STOP;
                        if (brake_cnt > 255)
                            brake_cnt = 255;
                    end
                    else if (d > near_mm)
                        mode_m = MODE_GO;
                    last_active = 1'b1;
                    if (mode_m == MODE_GO)
                    begin
                        last_speed = cfg_m.go_speed;
                        last_turn = turn_for_yaw(it.yaw_cdeg);
                    end
                    else
                    begin
                        last_speed = '0;
                        last_turn = '0;
                    end
                end
            end
            default: ;
        endcase
        r.cmd_active = last_active;
        r.speed_out = last_speed;
        r.turn_out = last_turn;
        r.poll_request = poll;
        r.follow_state = mode_m;
        return r;
    endfunction

    // receiver: random stall, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_req > 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            result_stall <= 1'b1;
        end
        else
            result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: active=%0d speed=%0d turn=%0d poll=%0d state=%0d",
                             result.cmd_active, result.speed_out, $signed(result.turn_out),
                             result.poll_request, result.follow_state);
            end
            else
            begin
                want = expected_q.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: want active=%0d speed=%0d turn=%0d poll=%0d state=%0d",
                                 want.cmd_active, want.speed_out, $signed(want.turn_out),
                                 want.poll_request, want.follow_state);
                        $display("          got  active=%0d speed=%0d turn=%0d poll=%0d state=%0d",
                                 result.cmd_active, result.speed_out, $signed(result.turn_out),
                                 result.poll_request, result.follow_state);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // entered and left just after a falling edge
    task automatic send_item(input item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        expected_q.push_back(follow_step(it));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic set_config(input cfg_t c);
        reg_write(REG_GO_SPEED, 16'(c.go_speed));
        reg_write(REG_NEAR_MM, c.near_threshold_mm);
        reg_write(REG_MAX_VALID_MM, c.max_valid_mm);
        reg_write(REG_BRAKE_TICKS, 16'(c.brake_ticks));
        reg_write(REG_POLL_TICKS, 16'(c.poll_ticks));
        reg_write(REG_HEADING_GAIN, {{5{c.heading_gain_tenths[10]}}, c.heading_gain_tenths});
        reg_write(REG_TURN_LIMIT, 16'(c.turn_limit));
        cfg_write_en <= 1'b0;
        cfg_m = c;
        @(negedge clk);
    endtask

    function automatic item_t make_item(input logic [1:0] c, input logic k, input logic rdy,
                                        input logic dn, input int d, input int y);
        item_t it;
        it.command = c;
        it.kill_active = k;
        it.sensor_ready = rdy;
        it.sample_done = dn;
        it.distance_mm = 16'(d);
        it.yaw_cdeg = 16'(y);
        return it;
    endfunction

    // clean items: ticks with a good sensor; otherwise anything goes
    function automatic item_t rand_item(input bit clean);
        item_t it;
        int near_mm;
        int maxv;
        int far_d;
        int near_d;
        int d;
        int y;
        int sel;
        near_mm = int'(cfg_m.near_threshold_mm);
        maxv = int'(cfg_m.max_valid_mm);
        far_d = (maxv > near_mm) ? $urandom_range(maxv, near_mm + 1) : $urandom_range(maxv);
        near_d = $urandom_range((near_mm < maxv) ? near_mm : maxv);
        sel = $urandom_range(99);
        if (clean)
            it.command = CMD_TICK;
        else if (sel < 80)
            it.command = CMD_TICK;
        else if (sel < 88)
            it.command = CMD_START;
        else if (sel < 95)
            it.command = CMD_STOP;
        else
            it.command = CMD_UNUSED;
        it.kill_active = $urandom_range(99) < (clean ? 3 : 15);
        it.sensor_ready = clean || ($urandom_range(99) < 80);
        it.sample_done = clean || ($urandom_range(99) < 80);
        sel = $urandom_range(9);
        if (clean)
            d = (sel < 7) ? far_d : near_d;
        else if (sel < 4)
            d = far_d;
        else if (sel < 6)
            d = near_d;
        else if (sel < 8)
            d = $urandom_range(65535);
        else if (sel == 8)
        begin
            case ($urandom_range(3))
                0: d = near_mm;
                1: d = near_mm + 1;
                2: d = maxv;
                default: d = maxv + 1;
            endcase
        end
        else
            d = $urandom_range(1) ? 65535 : 0;
        it.distance_mm = 16'(d);
        sel = $urandom_range(9);
        if (sel < 7)
        begin
            y = hdg_target + int'($urandom_range(6000)) - 3000;
            if (y > 18000)
                y -= 36000;
            if (y < -18000)
                y += 36000;
        end
        else if (sel < 9)
            y = int'($urandom_range(36000)) - 18000;
        else
        begin
            case ($urandom_range(3))
                0: y = -18000;
                1: y = 18000;
                2: y = 0;
                default: y = -1;
            endcase
        end
        it.yaw_cdeg = 16'(y);
        return it;
    endfunction

    function automatic cfg_t rand_settings();
        cfg_t c;
        int near_mm;
        near_mm = $urandom_range(3000);
        c.go_speed = 10'($urandom_range(1023));
        c.near_threshold_mm = 16'(near_mm);
        c.max_valid_mm = 16'(near_mm + int'($urandom_range(8000)));
        c.brake_ticks = 8'($urandom_range(30, 1));
        c.poll_ticks = 8'($urandom_range(255, 1));
        c.heading_gain_tenths = 11'(int'($urandom_range(2000)) - 1000);
        c.turn_limit = 15'($urandom_range(1) ? $urandom_range(32767) : $urandom_range(1000));
        return c;
    endfunction

    task automatic run_random(input int n);
        int run_left;
        bit clean;
        run_left = 0;
        clean = 1'b1;
        repeat (n)
        begin
            if (run_left == 0)
            begin
                clean = $urandom_range(99) < 80;
                run_left = $urandom_range(40, 5);
            end
            run_left--;
            send_item(rand_item(clean));
        end
    endtask

    // reset configuration, heading latch, wrap, kill, brake, ignored command
    task automatic test_directed();
        send_item(make_item(CMD_TICK, 1'b0, 1'b0, 1'b1, 1000, 0));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b0, 1000, 0));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 4001, 0));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 4000, 18000));
        send_item(make_item(CMD_UNUSED, 1'b0, 1'b1, 1'b1, 0, 0));
        send_item(make_item(CMD_START, 1'b0, 1'b1, 1'b1, 0, 9000));
        send_item(make_item(CMD_START, 1'b0, 1'b1, 1'b1, 0, -5000));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 501, -18000));
        send_item(make_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 0, 0));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 500, 9000));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 0, 9000));
        // invalid distance while braking
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 65535, 9000));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 600, 9000));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 600, 9100));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 600, 8900));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 600, -9000));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 3000, -1));
        send_item(make_item(CMD_STOP, 1'b1, 1'b0, 1'b0, 0, 0));
        send_item(make_item(CMD_TICK, 1'b1, 1'b1, 1'b1, 3000, 0));
        send_item(make_item(CMD_UNUSED, 1'b1, 1'b0, 1'b0, 65535, -1));
        send_item(make_item(CMD_START, 1'b1, 1'b1, 1'b1, 0, 0));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 0, 0));
        send_item(make_item(CMD_TICK, 1'b0, 1'b1, 1'b1, 2000, 18000));
        wait_idle();
    endtask

    task automatic run_phase(input cfg_t c, input int n);
        set_config(c);
        run_random(n);
        wait_idle();
    endtask

    task automatic test_settings();
        cfg_t c;
        c = '{go_speed: 10'd1023, near_threshold_mm: 16'd65535, max_valid_mm: 16'd65535,
              brake_ticks: 8'd255, poll_ticks: 8'd255, heading_gain_tenths: 11'sd1000,
              turn_limit: 15'd32767};
        run_phase(c, 60);
        c.near_threshold_mm = 16'd0;
        run_phase(c, 250);
        c = '{go_speed: 10'd0, near_threshold_mm: 16'd0, max_valid_mm: 16'd0,
              brake_ticks: 8'd1, poll_ticks: 8'd1, heading_gain_tenths: -11'sd1000,
              turn_limit: 15'd0};
        run_phase(c, 60);
        // zero tick counts: poll every tick, brake ends on its first tick
        c = '{go_speed: 10'd1, near_threshold_mm: 16'd100, max_valid_mm: 16'd3000,
              brake_ticks: 8'd0, poll_ticks: 8'd0, heading_gain_tenths: -11'sd1,
              turn_limit: 15'd1};
        run_phase(c, 200);
        c = '{go_speed: GO_SPEED_RST, near_threshold_mm: NEAR_MM_RST,
              max_valid_mm: MAX_VALID_MM_RST, brake_ticks: BRAKE_TICKS_RST,
              poll_ticks: POLL_TICKS_RST, heading_gain_tenths: HEADING_GAIN_RST,
              turn_limit: TURN_LIMIT_RST};
        run_phase(c, 250);
        repeat (3) run_phase(rand_settings(), 220);
    endtask

    task automatic test_no_idle();
        idle_pct = 0;
        stall_pct = 0;
        run_random(200);
        idle_pct = 31;
        stall_pct = 31;
    endtask

    // receiver holds off long enough for the pipe to fill and stall the input
    task automatic test_backpressure();
        idle_pct = 0;
        hold_req = 120;
        run_random(40);
        idle_pct = 31;
        wait_idle();
    endtask

    task automatic test_pause();
        repeat (5)
        begin
            run_random($urandom_range(40, 20));
            wait_idle();
        end
    endtask

    initial
    begin
        cfg_m = '{go_speed: GO_SPEED_RST, near_threshold_mm: NEAR_MM_RST,
                  max_valid_mm: MAX_VALID_MM_RST, brake_ticks: BRAKE_TICKS_RST,
                  poll_ticks: POLL_TICKS_RST, heading_gain_tenths: HEADING_GAIN_RST,
                  turn_limit: TURN_LIMIT_RST};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_settings();
        test_no_idle();
        test_backpressure();
        test_pause();
        wait_idle();
        if (mismatches == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
